>>> rtl/core/ppe_pkg.sv
// ppe_pkg: shared types, constants and helpers for the polynomial patch evaluator
// no dependencies; imported by the top level, ppe_front and ppe_back, and used by ppe_ram for default sizes
`timescale 1ns / 1ps

package ppe_pkg;

    localparam int MAX_TERMS_U_DEF = 4;
    localparam int MAX_TERMS_V_DEF = 4;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int DATA_W      = 32;
    localparam int NORM_W      = 16;
    localparam int ACC_W       = 72;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = 15;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        REG_U_ORIGIN     = 3'd0,
        REG_U_RECIP_SPAN = 3'd1,
        REG_V_ORIGIN     = 3'd2,
        REG_V_RECIP_SPAN = 3'd3,
        REG_TERMS_U      = 3'd4,
        REG_TERMS_V      = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic               command;
        logic [1:0]         coef_axis;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] u_coord;
        logic signed [31:0] v_coord;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               normal_degenerate;
    } result_t;

    typedef struct packed {
        logic signed [31:0] u_origin;
        logic signed [31:0] u_recip_span;
        logic signed [31:0] v_origin;
        logic signed [31:0] v_recip_span;
        logic [2:0]         terms_u;
        logic [2:0]         terms_v;
    } cfg_t;

    // request after decode, as it sits in the queue
    typedef struct packed {
        logic               is_eval;
        logic               wr_ok;
        logic [1:0]         coef_axis;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] u_coord;
        logic signed [31:0] v_coord;
    } qitem_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        if (x[ACC_W-1:31] == '0 || x[ACC_W-1:31] == '1)
            return x[31:0];
        else if (x[ACC_W-1])
            return 32'sh8000_0000;
        else
            return 32'sh7fff_ffff;
    endfunction

endpackage

>>> rtl/core/polynomial_patch_evaluator.sv
// polynomial_patch_evaluator: top level, configuration registers and wiring
// depends on ppe_pkg, ppe_front and ppe_back
`timescale 1ns / 1ps

// Evaluates one power-basis surface patch of up to MAX_TERMS_U by MAX_TERMS_V
// terms. A write request stores one coefficient, handled by the back end in its
// idle state. An evaluate request returns the Q16.16 position and a Q1.14 unit
// normal, or a zero normal with normal_degenerate set when the normal is
// degenerate. The time is set by the single shared 32x32 multiplier, which
// works through the basis powers and three products per coefficient and axis,
// then by the normalizing shift (one bit a cycle), the 32-step square root and
// three passes of a 15-step divider. A two-entry queue takes requests while an
// evaluation runs, and a result register holds a finished result while the
// next request proceeds. Configuration is to be written by the user only while
// the block is idle; the block itself does not enforce this.
module polynomial_patch_evaluator #(
    parameter int MAX_TERMS_U = ppe_pkg::MAX_TERMS_U_DEF,
    parameter int MAX_TERMS_V = ppe_pkg::MAX_TERMS_V_DEF,
    parameter int FRAC_BITS   = ppe_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ppe_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ppe_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    import ppe_pkg::*;

    cfg_t   cfg_reg;
    logic   head_valid;
    qitem_t head;
    logic   pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.u_origin     <= '0;
            cfg_reg.u_recip_span <= 32'(64'(1) << FRAC_BITS);
            cfg_reg.v_origin     <= '0;
            cfg_reg.v_recip_span <= 32'(64'(1) << FRAC_BITS);
            cfg_reg.terms_u      <= 3'd4;
            cfg_reg.terms_v      <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_U_ORIGIN:     cfg_reg.u_origin     <= cfg_data;
                REG_U_RECIP_SPAN: cfg_reg.u_recip_span <= cfg_data;
                REG_V_ORIGIN:     cfg_reg.v_origin     <= cfg_data;
                REG_V_RECIP_SPAN: cfg_reg.v_recip_span <= cfg_data;
                REG_TERMS_U:      cfg_reg.terms_u      <= cfg_data[2:0];
                REG_TERMS_V:      cfg_reg.terms_v      <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    ppe_front #(
        .MAX_TERMS_U (MAX_TERMS_U),
        .MAX_TERMS_V (MAX_TERMS_V)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    ppe_back #(
        .MAX_TERMS_U (MAX_TERMS_U),
        .MAX_TERMS_V (MAX_TERMS_V),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> rtl/core/ppe_ram.sv
// ppe_ram: generic single-write, single-read ram with registered read data
// depends on ppe_pkg for default sizes only
`timescale 1ns / 1ps

module ppe_ram #(
    parameter int WIDTH = ppe_pkg::DATA_W,
    parameter int DEPTH = ppe_pkg::MAX_TERMS_U_DEF * ppe_pkg::MAX_TERMS_V_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ppe_front.sv
// ppe_front: accepts requests, decodes them and holds them in a short queue
// depends on ppe_pkg
`timescale 1ns / 1ps

module ppe_front #(
    parameter int MAX_TERMS_U = ppe_pkg::MAX_TERMS_U_DEF,
    parameter int MAX_TERMS_V = ppe_pkg::MAX_TERMS_V_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  ppe_pkg::item_t  item,
    output logic            head_valid,
    output ppe_pkg::qitem_t head,
    input  logic            pop
);

    import ppe_pkg::*;

    localparam int PER_AXIS = MAX_TERMS_U * MAX_TERMS_V;

    qitem_t     qbuf_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    qitem_t     dec;
    logic       push;

    always_comb
    begin
        dec.is_eval    = (item.command == CMD_EVAL);
        dec.wr_ok      = (item.coef_axis <= AXIS_Z) && (int'(item.coef_index) < PER_AXIS);
        dec.coef_axis  = item.coef_axis;
        dec.coef_index = item.coef_index;
        dec.coef_value = item.coef_value;
        dec.u_coord    = item.u_coord;
        dec.v_coord    = item.v_coord;
    end

    assign item_stall = (count_reg == 2'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign head_valid = (count_reg != 2'd0);
    assign head       = qbuf_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                qbuf_reg[wr_ptr_reg] <= dec;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> rtl/core/ppe_back.sv
// ppe_back: sequencer that stores coefficients and evaluates position and normal
// depends on ppe_pkg and ppe_ram (basis table and coefficient store)
`timescale 1ns / 1ps

module ppe_back #(
    parameter int MAX_TERMS_U = ppe_pkg::MAX_TERMS_U_DEF,
    parameter int MAX_TERMS_V = ppe_pkg::MAX_TERMS_V_DEF,
    parameter int FRAC_BITS   = ppe_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ppe_pkg::cfg_t    cfg,
    input  logic             head_valid,
    input  ppe_pkg::qitem_t  head,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output ppe_pkg::result_t result
);

    import ppe_pkg::*;

    localparam int PER_AXIS    = MAX_TERMS_U * MAX_TERMS_V;
    localparam int STORE_DEPTH = 3 * PER_AXIS;
    localparam int KW          = $clog2(PER_AXIS + 1);
    localparam int BAW         = (PER_AXIS > 1) ? $clog2(PER_AXIS) : 1;
    localparam int CAW         = $clog2(STORE_DEPTH);
    localparam int MAXT        = (MAX_TERMS_U > MAX_TERMS_V) ? MAX_TERMS_U : MAX_TERMS_V;
    localparam int WW          = (MAXT > 2) ? $clog2(MAXT) : 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MAP_MUL, ST_MAP_RES, ST_B0, ST_B_RD, ST_B_MUL, ST_B_WR,
        ST_T_ISSUE, ST_T_DRAIN, ST_X_MUL1, ST_X_MUL2, ST_X_SUB, ST_N_CHK,
        ST_N_SHIFT, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT, ST_D_INIT, ST_D_STEP, ST_FINISH
    } state_t;

    state_t                    state_reg;
    logic signed [31:0]        u_reg, v_reg, s_reg, t_reg;
    logic                      map_sel_reg;
    logic [KW-1:0]             k_reg, i_reg, j_reg;
    logic [1:0]                sub_reg, axis_reg, c_reg;
    logic signed [63:0]        p_reg, p1_reg, p_next;
    logic                      s1_valid_reg, s2_valid_reg, s1_cvalid_reg;
    logic [1:0]                s1_axis_reg, s1_sub_reg, s2_axis_reg, s2_sub_reg;
    logic [WW-1:0]             s1_weight_reg, s2_weight_reg;
    logic signed [ACC_W-1:0]   acc_reg [3][3];
    logic [63:0]               mag_reg [3];
    logic                      neg_reg [3];
    logic [63:0]               sum_reg, x_reg, r_reg, bit_reg;
    logic [45:0]               rem_reg, d_reg;
    logic [DIV_STEPS-2:0]      q_reg;
    logic [3:0]                cnt_reg;
    logic signed [15:0]        norm_reg [3];
    logic                      degen_reg;
    logic [STORE_DEPTH-1:0]    cvalid_reg;
    result_t                   result_reg;
    logic                      result_valid_reg;

    logic [KW-1:0]             tu, tv, n_terms, km1, kmt;
    logic                      i_wrap, k_last;
    logic signed [31:0]        mul_a, mul_b;
    logic signed [31:0]        du [3];
    logic signed [31:0]        dv [3];
    logic [1:0]                c1, c2;
    logic [63:0]               mx;
    logic signed [64:0]        cdiff;
    logic [WW-1:0]             weight;
    logic                      b_we, c_we;
    logic [BAW-1:0]            b_waddr, b_raddr;
    logic [CAW-1:0]            c_waddr, c_raddr;
    logic [31:0]               b_wdata, b_rdata, c_rdata;
    logic                      qbit;
    logic [DIV_STEPS-1:0]      q_new;
    logic signed [ACC_W-1:0]   map_diff;

    function automatic logic signed [ACC_W-1:0] rnd_q(input logic signed [63:0] x);
        logic signed [64:0] y;
        y = $signed({x[63], x}) + $signed(65'(1) << (FRAC_BITS - 1));
        return ACC_W'(y >>> FRAC_BITS);
    endfunction

    always_comb
    begin
        if (cfg.terms_u == 3'd0)
            tu = KW'(1);
        else if (int'(cfg.terms_u) > MAX_TERMS_U)
            tu = KW'(MAX_TERMS_U);
        else
            tu = KW'(cfg.terms_u);
        if (cfg.terms_v == 3'd0)
            tv = KW'(1);
        else if (int'(cfg.terms_v) > MAX_TERMS_V)
            tv = KW'(MAX_TERMS_V);
        else
            tv = KW'(cfg.terms_v);
    end

    assign n_terms = KW'({{KW{1'b0}}, tu} * {{KW{1'b0}}, tv});
    assign km1     = k_reg - KW'(1);
    assign kmt     = k_reg - tu;
    assign i_wrap  = (i_reg == tu - KW'(1));
    assign k_last  = (k_reg == n_terms - KW'(1));

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            du[a] = sat32(acc_reg[a][1]);
            dv[a] = sat32(acc_reg[a][2]);
        end
    end

    always_comb
    begin
        case (c_reg)
            2'd0:    begin c1 = 2'd1; c2 = 2'd2; end
            2'd1:    begin c1 = 2'd2; c2 = 2'd0; end
            default: begin c1 = 2'd0; c2 = 2'd1; end
        endcase
    end

    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx) mx = mag_reg[1];
        if (mag_reg[2] > mx) mx = mag_reg[2];
    end

    assign cdiff = $signed({p1_reg[63], p1_reg}) - $signed({p_reg[63], p_reg});
    assign qbit  = (rem_reg >= d_reg);
    assign q_new = {q_reg, qbit};

    always_comb
    begin
        if (map_sel_reg)
            map_diff = ACC_W'(v_reg) - ACC_W'(cfg.v_origin);
        else
            map_diff = ACC_W'(u_reg) - ACC_W'(cfg.u_origin);
    end

    always_comb
    begin
        case (sub_reg)
            2'd1:    weight = WW'(i_reg);
            2'd2:    weight = WW'(j_reg);
            default: weight = WW'(1);
        endcase
    end

    always_comb
    begin
        pop     = 1'b0;
        b_we    = 1'b0;
        b_waddr = k_reg[BAW-1:0];
        b_wdata = sat32(rnd_q(p_reg));
        b_raddr = k_reg[BAW-1:0];
        c_we    = 1'b0;
        c_waddr = CAW'(head.coef_axis) * CAW'(PER_AXIS) + CAW'(head.coef_index);
        c_raddr = CAW'(axis_reg) * CAW'(PER_AXIS) + CAW'(k_reg);
        // by default the multiplier serves the coefficient stream
        mul_a   = b_rdata;
        mul_b   = s1_cvalid_reg ? c_rdata : 32'sd0;
        case (state_reg)
            ST_IDLE:
            begin
                pop  = head_valid;
                c_we = head_valid && !head.is_eval && head.wr_ok;
            end
            ST_MAP_MUL:
            begin
                mul_a = sat32(map_diff);
                mul_b = map_sel_reg ? cfg.v_recip_span : cfg.u_recip_span;
            end
            ST_B0:
            begin
                b_we    = 1'b1;
                b_waddr = '0;
                b_wdata = 32'(64'(1) << FRAC_BITS);
            end
            ST_B_RD:
            begin
                b_raddr = (j_reg == '0) ? km1[BAW-1:0] : kmt[BAW-1:0];
            end
            ST_B_MUL:
            begin
                mul_b = (j_reg == '0) ? s_reg : t_reg;
            end
            ST_B_WR:
            begin
                b_we = 1'b1;
            end
            ST_T_ISSUE:
            begin
                if (sub_reg == 2'd1 && i_reg != '0)
                    b_raddr = km1[BAW-1:0];
                else if (sub_reg == 2'd2 && j_reg != '0)
                    b_raddr = kmt[BAW-1:0];
            end
            ST_X_MUL1:
            begin
                mul_a = du[c1];
                mul_b = dv[c2];
            end
            ST_X_MUL2:
            begin
                mul_a = du[c2];
                mul_b = dv[c1];
            end
            ST_SQ_MUL:
            begin
                mul_a = $signed({2'b00, mag_reg[c_reg][29:0]});
                mul_b = $signed({2'b00, mag_reg[c_reg][29:0]});
            end
            default:
            begin
            end
        endcase
    end

    assign p_next = mul_a * mul_b;

    ppe_ram #(.WIDTH(DATA_W), .DEPTH(PER_AXIS)) u_basis_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    ppe_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (head.coef_value),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            cvalid_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            p_reg         <= p_next;
            s1_valid_reg  <= (state_reg == ST_T_ISSUE);
            s2_valid_reg  <= s1_valid_reg;
            s2_axis_reg   <= s1_axis_reg;
            s2_sub_reg    <= s1_sub_reg;
            s2_weight_reg <= s1_weight_reg;
            if (s2_valid_reg)
            begin
                acc_reg[s2_axis_reg][s2_sub_reg] <= acc_reg[s2_axis_reg][s2_sub_reg]
                    + rnd_q(p_reg) * ACC_W'($signed({1'b0, s2_weight_reg}));
            end
            if (result_valid_reg && !result_stall && state_reg != ST_FINISH)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        if (head.is_eval)
                        begin
                            u_reg       <= head.u_coord;
                            v_reg       <= head.v_coord;
                            map_sel_reg <= 1'b0;
                            for (int a = 0; a < 3; a++)
                                for (int b = 0; b < 3; b++)
                                    acc_reg[a][b] <= '0;
                            state_reg   <= ST_MAP_MUL;
                        end
                        else if (head.wr_ok)
                        begin
                            cvalid_reg[c_waddr] <= 1'b1;
                        end
                    end
                end
                ST_MAP_MUL:
                begin
                    state_reg <= ST_MAP_RES;
                end
                ST_MAP_RES:
                begin
                    if (!map_sel_reg)
                    begin
                        s_reg       <= sat32(rnd_q(p_reg));
                        map_sel_reg <= 1'b1;
                        state_reg   <= ST_MAP_MUL;
                    end
                    else
                    begin
                        t_reg     <= sat32(rnd_q(p_reg));
                        state_reg <= ST_B0;
                    end
                end
                ST_B0:
                begin
                    if (n_terms == KW'(1))
                    begin
                        k_reg     <= '0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        sub_reg   <= 2'd0;
                        axis_reg  <= AXIS_X;
                        state_reg <= ST_T_ISSUE;
                    end
                    else
                    begin
                        k_reg     <= KW'(1);
                        i_reg     <= (tu == KW'(1)) ? KW'(0) : KW'(1);
                        j_reg     <= (tu == KW'(1)) ? KW'(1) : KW'(0);
                        state_reg <= ST_B_RD;
                    end
                end
                ST_B_RD:
                begin
                    state_reg <= ST_B_MUL;
                end
                ST_B_MUL:
                begin
                    state_reg <= ST_B_WR;
                end
                ST_B_WR:
                begin
                    if (k_last)
                    begin
                        k_reg     <= '0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        sub_reg   <= 2'd0;
                        axis_reg  <= AXIS_X;
                        state_reg <= ST_T_ISSUE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + KW'(1);
                        i_reg     <= i_wrap ? KW'(0) : i_reg + KW'(1);
                        j_reg     <= i_wrap ? j_reg + KW'(1) : j_reg;
                        state_reg <= ST_B_RD;
                    end
                end
                ST_T_ISSUE:
                begin
                    s1_axis_reg   <= axis_reg;
                    s1_sub_reg    <= sub_reg;
                    s1_weight_reg <= weight;
                    s1_cvalid_reg <= cvalid_reg[c_raddr];
                    if (sub_reg == 2'd2)
                    begin
                        sub_reg <= 2'd0;
                        if (k_last)
                        begin
                            k_reg <= '0;
                            i_reg <= '0;
                            j_reg <= '0;
                            if (axis_reg == AXIS_Z)
                                state_reg <= ST_T_DRAIN;
                            else
                                axis_reg <= axis_reg + 2'd1;
                        end
                        else
                        begin
                            k_reg <= k_reg + KW'(1);
                            i_reg <= i_wrap ? KW'(0) : i_reg + KW'(1);
                            j_reg <= i_wrap ? j_reg + KW'(1) : j_reg;
                        end
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 2'd1;
                    end
                end
                ST_T_DRAIN:
                begin
                    if (!s1_valid_reg && !s2_valid_reg)
                    begin
                        c_reg     <= 2'd0;
                        state_reg <= ST_X_MUL1;
                    end
                end
                ST_X_MUL1:
                begin
                    state_reg <= ST_X_MUL2;
                end
                ST_X_MUL2:
                begin
                    p1_reg    <= p_reg;
                    state_reg <= ST_X_SUB;
                end
                ST_X_SUB:
                begin
                    neg_reg[c_reg] <= cdiff[64];
                    mag_reg[c_reg] <= cdiff[64] ? 64'(-cdiff) : cdiff[63:0];
                    if (c_reg == 2'd2)
                    begin
                        state_reg <= ST_N_CHK;
                    end
                    else
                    begin
                        c_reg     <= c_reg + 2'd1;
                        state_reg <= ST_X_MUL1;
                    end
                end
                ST_N_CHK:
                begin
                    if (mx == 64'd0)
                    begin
                        degen_reg <= 1'b1;
                        for (int a = 0; a < 3; a++)
                            norm_reg[a] <= '0;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        degen_reg <= 1'b0;
                        state_reg <= ST_N_SHIFT;
                    end
                end
                ST_N_SHIFT:
                begin
                    // one bit a cycle until the largest magnitude sits in [2^29, 2^30)
                    if (mx[63:30] != '0)
                    begin
                        for (int a = 0; a < 3; a++)
                            mag_reg[a] <= mag_reg[a] >> 1;
                    end
                    else if (mx[63:29] == '0)
                    begin
                        for (int a = 0; a < 3; a++)
                            mag_reg[a] <= mag_reg[a] << 1;
                    end
                    else
                    begin
                        c_reg     <= 2'd0;
                        sum_reg   <= '0;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_SQ_MUL:
                begin
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC:
                begin
                    sum_reg <= sum_reg + 64'(p_reg);
                    if (c_reg == 2'd2)
                    begin
                        x_reg     <= sum_reg + 64'(p_reg);
                        r_reg     <= '0;
                        bit_reg   <= 64'(1) << 62;
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        c_reg     <= c_reg + 2'd1;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_SQRT:
                begin
                    if (x_reg >= r_reg + bit_reg)
                    begin
                        x_reg <= x_reg - (r_reg + bit_reg);
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == 64'd1)
                    begin
                        c_reg     <= 2'd0;
                        state_reg <= ST_D_INIT;
                    end
                end
                ST_D_INIT:
                begin
                    // numerator carries half the length for round to nearest
                    rem_reg   <= (46'(mag_reg[c_reg][29:0]) << 14) + 46'(r_reg[31:1]);
                    d_reg     <= 46'(r_reg[31:0]) << 14;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_D_STEP;
                end
                ST_D_STEP:
                begin
                    if (qbit)
                        rem_reg <= rem_reg - d_reg;
                    d_reg   <= d_reg >> 1;
                    q_reg   <= q_new[DIV_STEPS-2:0];
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(DIV_STEPS - 1))
                    begin
                        norm_reg[c_reg] <= neg_reg[c_reg] ? -$signed({1'b0, q_new})
                                                          : $signed({1'b0, q_new});
                        if (c_reg == 2'd2)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            c_reg     <= c_reg + 2'd1;
                            state_reg <= ST_D_INIT;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg.pos_x             <= sat32(acc_reg[0][0]);
                        result_reg.pos_y             <= sat32(acc_reg[1][0]);
                        result_reg.pos_z             <= sat32(acc_reg[2][0]);
                        result_reg.norm_x            <= norm_reg[0];
                        result_reg.norm_y            <= norm_reg[1];
                        result_reg.norm_z            <= norm_reg[2];
                        result_reg.normal_degenerate <= degen_reg;
                        result_valid_reg             <= 1'b1;
                        state_reg                    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
